[rtl/srtf_pkg.sv]
package srtf_pkg;

  localparam int MAX_PROCS = 16;
  localparam int SLOT_W    = $clog2(MAX_PROCS);
  localparam int TREE_N    = 1 << SLOT_W;

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;
  localparam int RATIO_W = 24;
  localparam int FRAC_W  = 8;
  localparam int DVD_W   = TIME_W + FRAC_W;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_ZERO = 2'd2;

  // One candidate in the minimum-search tree.
  typedef struct packed {
    logic               elig;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  arrival;
    logic [ID_W-1:0]    ident;
    logic [SLOT_W-1:0]  slot;
  } key_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;
    logic sub_write;
    logic sub_reject;
    logic tick;
    logic calc;
    logic div_start;
    logic div_store;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic action;
    logic zero_burst;
    logic table_full;
    logic found;
    logic last;
    logic div_done;
    logic out_free;
  } stat_t;

  // The left operand always holds the lower slots, so a full tie keeps it.
  function automatic key_t pick_better(key_t a, key_t b);
    key_t r;
    if (!a.elig) begin
      r = b;
    end else if (!b.elig) begin
      r = a;
    end else if (a.remaining != b.remaining) begin
      r = (a.remaining < b.remaining) ? a : b;
    end else if (a.arrival != b.arrival) begin
      r = (a.arrival < b.arrival) ? a : b;
    end else if (a.ident != b.ident) begin
      r = (a.ident < b.ident) ? a : b;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

[rtl/srtf_div.sv]
module srtf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [srtf_pkg::DVD_W-1:0]   dividend,
  input  logic [srtf_pkg::BURST_W-1:0] divisor,
  output logic                      done,
  output logic [srtf_pkg::DVD_W-1:0]   quotient
);
  import srtf_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(DVD_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [BURST_W-1:0] rem;
  logic [BURST_W-1:0] dsr;
  logic [BURST_W:0]   trial;
  logic [BURST_W:0]   diff;
  logic               ge;

  // Restoring division, one quotient bit per cycle; the quotient shifts
  // into the register that held the dividend.
  assign trial = {rem, quotient[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[BURST_W-1:0] : trial[BURST_W-1:0];
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule

[rtl/srtf_datapath.sv]
module srtf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  srtf_pkg::cmd_t      cmd,
  output srtf_pkg::stat_t     stat,
  input  logic [31:0]         s_tdata,
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [135:0]        m_tdata,
  output logic [1:0]          m_tuser
);
  import srtf_pkg::*;

  // Latched input item.
  logic [ID_W-1:0]    in_id;
  logic [BURST_W-1:0] in_burst;

  // Process table.
  logic               entry_valid     [MAX_PROCS];
  logic [ID_W-1:0]    entry_ident     [MAX_PROCS];
  logic [TIME_W-1:0]  entry_arrival   [MAX_PROCS];
  logic [BURST_W-1:0] entry_burst     [MAX_PROCS];
  logic [BURST_W-1:0] entry_remaining [MAX_PROCS];
  logic [TIME_W-1:0]  sys_time;

  logic [SLOT_W-1:0]  free_slot;
  logic               table_full;
  logic [TIME_W-1:0]  time_inc;

  // Registered minimum-search tree: node_q[1] is the root.
  key_t node_q [1:TREE_N-1];
  key_t heap   [1:2*TREE_N-1];
  key_t root;

  // Result being built.
  logic [1:0]         res_kind;
  logic [ID_W-1:0]    res_id;
  logic [TIME_W-1:0]  res_ct;
  logic [TIME_W-1:0]  res_arr;
  logic [TIME_W-1:0]  res_ta;
  logic [TIME_W-1:0]  res_wt;
  logic [BURST_W-1:0] res_burst;
  logic [RATIO_W-1:0] res_ratio;

  logic               div_done;
  logic [DVD_W-1:0]   div_quot;
  logic [RATIO_W-1:0] ratio_sat;

  always_comb begin
    free_slot  = '0;
    table_full = 1'b1;
    for (int s = MAX_PROCS - 1; s >= 0; s--) begin
      if (!entry_valid[s]) begin
        free_slot  = SLOT_W'(s);
        table_full = 1'b0;
      end
    end
  end

  assign time_inc = (sys_time == TIME_MAX) ? sys_time : sys_time + 1'b1;

  always_comb begin
    for (int i = 1; i < TREE_N; i++) begin
      heap[i] = node_q[i];
    end
    for (int k = 0; k < TREE_N; k++) begin
      heap[TREE_N + k] = '0;
      heap[TREE_N + k].slot = SLOT_W'(k);
      if (k < MAX_PROCS) begin
        heap[TREE_N + k].elig      = entry_valid[k] && (entry_arrival[k] <= sys_time);
        heap[TREE_N + k].remaining = entry_remaining[k];
        heap[TREE_N + k].arrival   = entry_arrival[k];
        heap[TREE_N + k].ident     = entry_ident[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i < TREE_N; i++) begin
      node_q[i] <= pick_better(heap[2 * i], heap[2 * i + 1]);
    end
  end

  assign root = node_q[1];

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_id     <= s_tdata[15:0];
      in_burst  <= s_tdata[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_time <= '0;
      for (int s = 0; s < MAX_PROCS; s++) begin
        entry_valid[s] <= 1'b0;
      end
    end else begin
      if (cmd.sub_write) begin
        entry_valid[free_slot] <= 1'b1;
      end
      if (cmd.tick) begin
        sys_time <= time_inc;
        if (root.elig && root.remaining == BURST_W'(1)) begin
          entry_valid[root.slot] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sub_write) begin
      entry_ident[free_slot]     <= in_id;
      entry_arrival[free_slot]   <= sys_time;
      entry_burst[free_slot]     <= in_burst;
      entry_remaining[free_slot] <= in_burst;
    end
    if (cmd.tick && root.elig) begin
      entry_remaining[root.slot] <= root.remaining - 1'b1;
    end
  end

  assign ratio_sat = (|div_quot[DVD_W-1:RATIO_W]) ? RATIO_MAX : div_quot[RATIO_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sub_reject) begin
      res_kind  <= (in_burst == '0) ? KIND_ZERO : KIND_FULL;
      res_id    <= in_id;
      res_ct    <= '0;
      res_ta    <= '0;
      res_wt    <= '0;
      res_ratio <= '0;
    end
    if (cmd.tick) begin
      res_kind  <= KIND_DONE;
      res_id    <= root.ident;
      res_ct    <= time_inc;
      res_arr   <= root.arrival;
      res_burst <= entry_burst[root.slot];
    end
    if (cmd.calc) begin
      res_ta <= res_ct - res_arr;
    end
    if (cmd.div_start) begin
      res_wt <= (res_ta >= TIME_W'(res_burst)) ? res_ta - TIME_W'(res_burst) : '0;
    end
    if (cmd.div_store) begin
      res_ratio <= ratio_sat;
    end
  end

  srtf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({res_ta, {FRAC_W{1'b0}}}),
    .divisor  (res_burst),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Output register: holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= res_kind;
      m_tdata <= {res_ratio, res_wt, res_ta, res_ct, res_id};
    end
  end

  // The action is decoded at the accepting edge, so it comes straight from the bus.
  always_comb begin
    stat            = '0;
    stat.action     = s_tuser;
    stat.zero_burst = (in_burst == '0);
    stat.table_full = table_full;
    stat.found      = root.elig;
    stat.last       = (root.remaining == BURST_W'(1));
    stat.div_done   = div_done;
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

[rtl/srtf_ctrl.sv]
module srtf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  srtf_pkg::stat_t stat,
  output srtf_pkg::cmd_t  cmd
);
  import srtf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUBMIT,
    ST_SEARCH,
    ST_CALC,
    ST_DSTART,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  localparam int SRCH_W = $clog2(SLOT_W + 1);
  localparam logic [SRCH_W-1:0] SRCH_LAST = SRCH_W'(SLOT_W);

  state_t            state;
  logic [SRCH_W-1:0] srch_cnt;
  logic              accept;
  logic              reject;

  assign accept = s_tvalid && s_tready;
  assign reject = stat.zero_burst || stat.table_full;

  always_comb begin
    cmd            = '0;
    cmd.take_in    = accept;
    cmd.sub_write  = (state == ST_SUBMIT) && !reject;
    cmd.sub_reject = (state == ST_SUBMIT) && reject;
    cmd.tick       = (state == ST_SEARCH) && (srch_cnt == SRCH_LAST);
    cmd.calc       = (state == ST_CALC);
    cmd.div_start  = (state == ST_DSTART);
    cmd.div_store  = (state == ST_DIVIDE) && stat.div_done;
    cmd.out_load   = (state == ST_EMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
      srch_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            s_tready <= 1'b0;
            srch_cnt <= '0;
            state    <= (s_tvalid && stat.action == ACT_TICK) ? ST_SEARCH : ST_SUBMIT;
          end
        end
        ST_SUBMIT: begin
          if (reject) begin
            state <= ST_EMIT;
          end else begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        ST_SEARCH: begin
          // The search waits for every registered level of the tree to settle on the new table.
          if (srch_cnt == SRCH_LAST) begin
            if (stat.found && stat.last) begin
              state <= ST_CALC;
            end else begin
              state    <= ST_IDLE;
              s_tready <= 1'b1;
            end
          end else begin
            srch_cnt <= srch_cnt + 1'b1;
          end
        end
        ST_CALC: begin
          state <= ST_DSTART;
        end
        ST_DSTART: begin
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (stat.div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (stat.out_free) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

endmodule

[rtl/srtf_preemptive_scheduler.sv]
// Channel  Dir  tdata (low bit first)                                  tuser
// s_*      in   proc_id[15:0], burst_length[31:16]                     action
// m_*      out  done_id[15:0], finish_time[47:16],                     kind[1:0]
//               turnaround[79:48], waiting[111:80], ratio[135:112]
//
// A submit passes through the submit state before the next transfer, and a rejected
// one also through the emit state. A tick waits on the registered compare tree,
// which settles one level per cycle; a tick that completes a process adds the
// calculation states and the one-bit-per-cycle ratio divider.
// Reset is synchronous and empties the table at once. A result waiting in the
// output register does not block the next input item; only a second result stalls.
module srtf_preemptive_scheduler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // proc_id, burst_length
  input  logic         s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // done_id, finish_time, turnaround, waiting, ratio
  output logic [1:0]   m_tuser    // kind
);
  import srtf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  srtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srtf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[rtl/srtf_checker.sv]
module srtf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic [1:0]   m_tuser
);
  import srtf_pkg::*;

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Rejected submits carry zero timing fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_DONE |-> m_tdata[135:16] == '0)
    else $error("reject result has nonzero fields");

  // Waiting time never exceeds turnaround.
  a_wait_le_ta: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_DONE |-> m_tdata[111:80] <= m_tdata[79:48])
    else $error("waiting exceeds turnaround");

  // The block takes no new item while it is still building a result.
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after a transfer");

endmodule

bind srtf_preemptive_scheduler srtf_checker u_chk (.*);

[dv/tb_top.sv]
module tb_top;
  import srtf_pkg::*;

  typedef struct packed {
    logic               action;
    logic [ID_W-1:0]    pid;
    logic [BURST_W-1:0] burst;
  } job_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  finish_at;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [RATIO_W-1:0] ratio;
  } outcome_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic         s_tuser = ACT_SUBMIT;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [1:0]   m_tuser;

  job_t     job_queue[$];
  outcome_t pending_results[$];
  int       mismatches = 0;

  // Shadow copy of the process table.
  logic               slot_busy[MAX_PROCS];
  logic [ID_W-1:0]    slot_id[MAX_PROCS];
  logic [TIME_W-1:0]  slot_arrival[MAX_PROCS];
  logic [BURST_W-1:0] slot_burst[MAX_PROCS];
  logic [BURST_W-1:0] slot_left[MAX_PROCS];
  logic [TIME_W-1:0]  sched_clock = '0;

  srtf_preemptive_scheduler DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      slot_busy[i] = 1'b0;
    end
  end

  // Applies one job to the shadow table; returns 1 when it yields a result.
  function automatic bit schedule_job(input job_t j, output outcome_t r);
    int pick;
    int free_slot;
    logic [47:0] quot;
    r = '0;
    pick = -1;
    free_slot = -1;
    if (j.action == ACT_SUBMIT) begin
      r.id = j.pid;
      if (j.burst == 0) begin
        r.kind = KIND_ZERO;
        return 1'b1;
      end
      for (int s = MAX_PROCS - 1; s >= 0; s--) begin
        if (!slot_busy[s]) free_slot = s;
      end
      if (free_slot < 0) begin
        r.kind = KIND_FULL;
        return 1'b1;
      end
      slot_busy[free_slot]    = 1'b1;
      slot_id[free_slot]      = j.pid;
      slot_arrival[free_slot] = sched_clock;
      slot_burst[free_slot]   = j.burst;
      slot_left[free_slot]    = j.burst;
      return 1'b0;
    end
    for (int s = 0; s < MAX_PROCS; s++) begin
      if (slot_busy[s] && slot_arrival[s] <= sched_clock) begin
        if (pick < 0) begin
          pick = s;
        end else if (slot_left[s] != slot_left[pick]) begin
          if (slot_left[s] < slot_left[pick]) pick = s;
        end else if (slot_arrival[s] != slot_arrival[pick]) begin
          if (slot_arrival[s] < slot_arrival[pick]) pick = s;
        end else if (slot_id[s] < slot_id[pick]) begin
          pick = s;
        end
      end
    end
    if (sched_clock != TIME_MAX) sched_clock = sched_clock + 1'b1;
    if (pick < 0) return 1'b0;
    slot_left[pick] = slot_left[pick] - 1'b1;
    if (slot_left[pick] != 0) return 1'b0;
    r.kind       = KIND_DONE;
    r.id         = slot_id[pick];
    r.finish_at  = sched_clock;
    r.turnaround = sched_clock - slot_arrival[pick];
    r.waiting    = (r.turnaround >= slot_burst[pick]) ? r.turnaround - slot_burst[pick] : '0;
    quot = ({16'b0, r.turnaround} << FRAC_W) / {32'b0, slot_burst[pick]};
    r.ratio = (quot > {24'b0, RATIO_MAX}) ? RATIO_MAX : quot[RATIO_W-1:0];
    slot_busy[pick] = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    end
    mismatches++;
  endtask

  task automatic add_job(input logic act, input logic [15:0] pid, input logic [15:0] burst);
    job_t j;
    j.action = act;
    j.pid    = pid;
    j.burst  = burst;
    job_queue.push_back(j);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: presents queued jobs, with occasional calm stretches that have no gaps.
  int  send_gap = 0;
  int  sent_count = 0;
  bit  send_calm = 1'b0;
  always @(posedge clk) begin
    job_t     cur;
    outcome_t res;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        cur.action = s_tuser;
        cur.pid    = s_tdata[15:0];
        cur.burst  = s_tdata[31:16];
        if (schedule_job(cur, res)) pending_results.push_back(res);
        sent_count++;
        if (sent_count % 100 == 0) send_calm = ($urandom_range(0, 3) == 0);
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (job_queue.size() > 0) begin
          cur = job_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cur.action;
          s_tdata  <= {cur.burst, cur.pid};
          send_gap = send_calm ? 0 : pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, and every transfer checked against the oldest prediction.
  int stall_left = 0;
  int recv_count = 0;
  bit recv_calm = 1'b0;
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        recv_count++;
        if (recv_count % 80 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, done_id", 32'(m_tdata[15:0]), '0);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser != want.kind) report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
          if (m_tdata[15:0] != want.id)
            report_mismatch("done_id", 32'(m_tdata[15:0]), 32'(want.id));
          if (m_tdata[47:16] != want.finish_at)
            report_mismatch("finish_time", m_tdata[47:16], want.finish_at);
          if (m_tdata[79:48] != want.turnaround)
            report_mismatch("turnaround", m_tdata[79:48], want.turnaround);
          if (m_tdata[111:80] != want.waiting)
            report_mismatch("waiting", m_tdata[111:80], want.waiting);
          if (m_tdata[135:112] != want.ratio)
            report_mismatch("ratio", 32'(m_tdata[135:112]), 32'(want.ratio));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!recv_calm && $urandom_range(0, 9) < 3) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int submit_pct;
    int roll;
    int total_jobs;
    logic [15:0] pid;
    logic [15:0] burst;

    // Zero burst with an all-ones id, then a tick on an empty table.
    add_job(ACT_SUBMIT, 16'hFFFF, 16'h0000);
    add_job(ACT_TICK, 16'hA5A5, 16'h5A5A);
    // Equal remaining time and arrival: lower id wins, then the lower slot on a duplicate.
    add_job(ACT_SUBMIT, 16'd5, 16'd1);
    add_job(ACT_SUBMIT, 16'd3, 16'd1);
    add_job(ACT_SUBMIT, 16'd3, 16'd1);
    repeat (3) add_job(ACT_TICK, 16'h0000, 16'hFFFF);
    // Fill every slot, one of them with the longest burst, then overflow.
    add_job(ACT_SUBMIT, 16'hFFFF, 16'hFFFF);
    add_job(ACT_SUBMIT, 16'h0000, 16'd1);
    for (int i = 2; i < MAX_PROCS; i++) begin
      add_job(ACT_SUBMIT, 16'(i * 16'h1111), 16'($urandom_range(1, 6)));
    end
    add_job(ACT_SUBMIT, 16'h1234, 16'd5);
    // The zero-burst check takes precedence over a full table.
    add_job(ACT_SUBMIT, 16'h4321, 16'd0);

    // Random traffic in blocks whose submit share varies, so the table both drains
    // and runs full.
    submit_pct = 30;
    for (int n = 0; n < 1250; n++) begin
      if (n % 50 == 0) submit_pct = $urandom_range(15, 60);
      if ($urandom_range(0, 99) < submit_pct) begin
        pid = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        roll = $urandom_range(0, 499);
        if (roll < 20) burst = '0;
        else if (roll == 20) burst = 16'($urandom);
        else burst = 16'($urandom_range(1, $urandom_range(1, 10)));
        add_job(ACT_SUBMIT, pid, burst);
      end else begin
        add_job(ACT_TICK, 16'($urandom), 16'($urandom));
      end
    end
    total_jobs = job_queue.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_jobs || pending_results.size() > 0) @(posedge clk);
    // Let any stray result show up.
    repeat (100) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/srtf_pkg.sv
rtl/srtf_div.sv
rtl/srtf_datapath.sv
rtl/srtf_ctrl.sv
rtl/srtf_preemptive_scheduler.sv
rtl/srtf_checker.sv
dv/tb_top.sv
